// File: sv/ecc_pkg.sv
`default_nettype none

package ecc_pkg;

  // Field widths of the stream and configuration ports
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned IDX_IN_W   = 16;
  localparam int unsigned HIT_W      = 8;
  localparam int unsigned MAP_IDX_W  = 16;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned S_TDATA_W  = ADDR_W + IDX_IN_W;
  localparam int unsigned M_TDATA_W  = HIT_W + MAP_IDX_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Location hash: low address word times this constant, 32-bit wrap
  localparam int unsigned LOC_W = 32;
  localparam logic [15:0] LOC_MULT = 16'd33533;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_THREAD = 2'd2,
    OP_NONE   = 2'd3
  } ecc_op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INSTRUMENT_ALL = 2'd0,
    CFG_MODULE_START   = 2'd1,
    CFG_MODULE_END     = 2'd2,
    CFG_UNUSED         = 2'd3
  } ecc_cfg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture request, range check, hash product
    logic mod_start;  // start location reduction
    logic edge_rd;    // form edge, read counter, advance previous location
    logic idx_rd;     // read counter at entry index
    logic prev_clr;   // new thread
    logic upd;        // write counter back, form result
    logic res_zero;   // result without a counter access
    logic emit;       // move result to the output register
    logic clr_wr;     // clearing pass write
  } ecc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    ecc_op_e op;
    logic    take;      // record request lies in range or all are taken
    logic    idx_ok;    // entry index inside the map
    logic    mod_done;  // location ready
    logic    clr_last;  // clearing pass at last entry
    logic    out_free;  // output register can take a result
  } ecc_sts_t;

endpackage

`default_nettype wire

// File: sv/ecc_ctrl.sv
`default_nettype none

module ecc_ctrl
  import ecc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  ecc_sts_t sts_i,
  output ecc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_UPD,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_valid_i && ready_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.op)
          OP_RECORD: begin
            if (sts_i.take) begin
              cmd_o.mod_start = 1'b1;
              state_d         = ST_MOD;
            end else begin
              cmd_o.res_zero = 1'b1;
              state_d        = ST_EMIT;
            end
          end
          OP_READ: begin
            if (sts_i.idx_ok) begin
              cmd_o.idx_rd = 1'b1;
              state_d      = ST_UPD;
            end else begin
              cmd_o.res_zero = 1'b1;
              state_d        = ST_EMIT;
            end
          end
          OP_THREAD: begin
            cmd_o.prev_clr = 1'b1;
            cmd_o.res_zero = 1'b1;
            state_d        = ST_EMIT;
          end
          default: begin
            cmd_o.res_zero = 1'b1;
            state_d        = ST_EMIT;
          end
        endcase
      end
      ST_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.edge_rd = 1'b1;
          state_d       = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and input ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign s_ready_o = ready_q;

endmodule

`default_nettype wire

// File: sv/ecc_mod.sv
`default_nettype none

module ecc_mod
  import ecc_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 65536,
  localparam int unsigned IDX_W = $clog2(MAP_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LOC_W-1:0] operand_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  localparam bit POW2 = (MAP_ENTRIES == (64'd1 << IDX_W));

  if (POW2) begin : g_mask
    // Power-of-two map: remainder is the low bits
    logic             done_q;
    logic [IDX_W-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) rem_q <= operand_i[IDX_W-1:0];
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    // Reciprocal quotient estimate (low by at most one), then one
    // compare and subtract; done rises as the corrected remainder is registered
    localparam logic [LOC_W-1:0] RECIP = LOC_W'((64'd1 << LOC_W) / MAP_ENTRIES);
    localparam logic [LOC_W-1:0] N_C   = LOC_W'(MAP_ENTRIES);

    logic [2*LOC_W-1:0] qprod;
    logic [LOC_W-1:0]   nq;
    logic [LOC_W-1:0]   q_q;
    logic [LOC_W-1:0]   diff_q;
    logic [IDX_W-1:0]   rem_q;
    logic               s1_q;
    logic               s2_q;
    logic               done_q;

    assign qprod = 64'(operand_i) * 64'(RECIP);
    assign nq    = q_q * N_C;

    // Stage tracking
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        s1_q <= start_i;
        s2_q <= s1_q;
        if (start_i) begin
          done_q <= 1'b0;
        end else if (s2_q) begin
          done_q <= 1'b1;
        end
      end
    end

    // Quotient, partial remainder, final correction
    always_ff @(posedge clk_i) begin
      if (start_i) q_q <= qprod[2*LOC_W-1:LOC_W];
      if (s1_q) diff_q <= operand_i - nq;
      if (s2_q) rem_q <= (diff_q >= N_C) ? IDX_W'(diff_q - N_C) : IDX_W'(diff_q);
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule

`default_nettype wire

// File: sv/ecc_dp.sv
`default_nettype none

module ecc_dp
  import ecc_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request payload
  input  logic [S_TDATA_W-1:0]  s_tdata_i,
  input  logic [CMD_W-1:0]      s_tuser_i,
  // result register
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [M_TDATA_W-1:0]  m_tdata_o,
  output logic                  m_tuser_o,
  // controller
  input  ecc_cmd_t              cmd_i,
  output ecc_sts_t              sts_o
);

  localparam int unsigned IDX_W  = $clog2(MAP_ENTRIES);
  localparam int unsigned PREV_W = IDX_W - 1;
  localparam logic [IDX_W:0] N_C = (IDX_W + 1)'(MAP_ENTRIES);

  // Configuration
  logic                  all_q;
  logic [ADDR_W-1:0]     start_q;
  logic [ADDR_W-1:0]     end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q   <= 1'b0;
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (ecc_cfg_e'(cfg_index_i))
        CFG_INSTRUMENT_ALL: all_q   <= cfg_data_i[0];
        CFG_MODULE_START:   start_q <= cfg_data_i;
        CFG_MODULE_END:     end_q   <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // Request capture: range check and hash product
  logic [ADDR_W-1:0]   in_addr;
  logic [IDX_IN_W-1:0] in_idx;
  logic                in_inside;
  logic [47:0]         prod_full;

  ecc_op_e             op_q;
  logic [IDX_IN_W-1:0] idx_q;
  logic                inside_q;
  logic [LOC_W-1:0]    prod_q;

  assign in_addr   = s_tdata_i[ADDR_W-1:0];
  assign in_idx    = s_tdata_i[S_TDATA_W-1:ADDR_W];
  assign in_inside = (in_addr >= start_q) && (in_addr < end_q);
  assign prod_full = {16'b0, in_addr[LOC_W-1:0]} * {32'b0, LOC_MULT};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q     <= ecc_op_e'(s_tuser_i);
      idx_q    <= in_idx;
      inside_q <= in_inside;
      prod_q   <= prod_full[LOC_W-1:0];
    end
  end

  // Location reduction
  logic             mod_done;
  logic [IDX_W-1:0] loc;

  ecc_mod #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mod_start),
    .operand_i(prod_q),
    .done_o   (mod_done),
    .rem_o    (loc)
  );

  // Edge index and previous location
  logic [PREV_W-1:0] prev_q;
  logic [IDX_W-1:0]  edge_x;
  logic [IDX_W:0]    edge_xw;
  logic [IDX_W-1:0]  edge_n;
  logic [IDX_W-1:0]  edge_q;

  assign edge_x  = loc ^ {1'b0, prev_q};
  assign edge_xw = {1'b0, edge_x};
  assign edge_n  = (edge_xw >= N_C) ? IDX_W'(edge_xw - N_C) : edge_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (cmd_i.prev_clr) begin
      prev_q <= '0;
    end else if (cmd_i.edge_rd) begin
      prev_q <= loc[IDX_W-1:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_rd) edge_q <= edge_n;
  end

  // Entry index check
  logic [31:0]      idx_w;
  logic [IDX_W-1:0] idx_addr;
  logic             idx_ok;

  assign idx_w    = 32'(idx_q);
  assign idx_addr = idx_w[IDX_W-1:0];
  assign idx_ok   = idx_w < 32'(MAP_ENTRIES);

  // Clearing pass counter
  logic [IDX_W-1:0] clr_q;
  logic             clr_last;

  assign clr_last = (clr_q == IDX_W'(MAP_ENTRIES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr && !clr_last) begin
      clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Counter memory, one read and one write port
  logic [HIT_W-1:0] mem_q [MAP_ENTRIES];
  logic [HIT_W-1:0] rd_q;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [HIT_W-1:0] mem_wd;
  logic [HIT_W-1:0] inc;
  logic             is_rec;

  assign is_rec = (op_q == OP_RECORD);
  assign inc    = rd_q + HIT_W'(1);
  assign mem_re = cmd_i.edge_rd || cmd_i.idx_rd;
  assign mem_ra = cmd_i.edge_rd ? edge_n : idx_addr;
  assign mem_we = cmd_i.clr_wr || cmd_i.upd;

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (is_rec) begin
      mem_wa = edge_q;
      mem_wd = inc;
    end else begin
      mem_wa = idx_addr;
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_q <= mem_q[mem_ra];
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  // Result holding register
  logic [31:0]          edge_w;
  logic [HIT_W-1:0]     res_hit_q;
  logic [MAP_IDX_W-1:0] res_map_q;
  logic                 res_rec_q;

  assign edge_w = 32'(edge_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      res_hit_q <= is_rec ? inc : rd_q;
      res_map_q <= is_rec ? edge_w[MAP_IDX_W-1:0] : idx_q;
      res_rec_q <= is_rec;
    end else if (cmd_i.res_zero) begin
      res_hit_q <= '0;
      res_map_q <= (op_q == OP_READ) ? idx_q : '0;
      res_rec_q <= 1'b0;
    end
  end

  // Output register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic                 m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_data_q <= {res_map_q, res_hit_q};
      m_user_q <= res_rec_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  // Status
  always_comb begin
    sts_o          = '0;
    sts_o.op       = op_q;
    sts_o.take     = all_q || inside_q;
    sts_o.idx_ok   = idx_ok;
    sts_o.mod_done = mod_done;
    sts_o.clr_last = clr_last;
    sts_o.out_free = !m_valid_q || m_tready_i;
  end

endmodule

`default_nettype wire

// File: sv/edge_coverage_counter_map.sv
`default_nettype none

// Edge coverage counter map. Each record request (tuser command 0) hashes the
// low 32 bits of a block address times 33533 into a map location, increments
// the 8-bit counter at location XOR previous location (wrapping at 255) and
// returns the new count; previous becomes location >> 1. Blocks outside
// [module_start, module_end) are ignored unless instrument_all is set. Command
// 1 returns one counter and clears it; command 2 clears the previous location.
// Every request gives exactly one result. A record passes through the location
// remainder unit, which masks the low bits when MAP_ENTRIES is a power of two
// and uses a reciprocal estimate otherwise, then through one read-modify-write
// pass of the counter memory; a read also makes one such pass, and other
// commands access no counter. One request is in flight at a time; a result
// held in the output register does not stop the next request being accepted.
// After reset the block runs a clearing pass over all MAP_ENTRIES counters, one
// counter per cycle, before s_axis_tready rises; configuration writes are
// accepted at all times.
module edge_coverage_counter_map
  import ecc_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // block_address[63:0], entry_index[79:64]
  input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // hit_count[7:0], map_index[23:8]
  output logic                  m_axis_tuser   // recorded
);

  ecc_cmd_t cmd;
  ecc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ecc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  ecc_dp #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire
